// ===== design/kwm_pkg.sv =====
// Shared codes and control types for the k-way merge winner tree.
package kwm_pkg;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_RUN = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic is_pop;
    logic bad_run;
  } kwm_ctrl_t;

endpackage

// ===== design/kwm_front.sv =====
// Front end: accepts transactions, classifies them and queues them for the back end.
module kwm_front import kwm_pkg::*; #(
  parameter int MAX_RUNS    = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int RW = $clog2(MAX_RUNS),
  localparam int CW = $clog2(MAX_RUNS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CW-1:0]          k_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [RW-1:0]          run_index_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output kwm_ctrl_t              q_ctrl_o,
  output logic [RW-1:0]          q_run_o,
  output logic [VALUE_WIDTH-1:0] q_value_o
);

  kwm_ctrl_t              ctrl_q  [2];
  logic [RW-1:0]          run_q   [2];
  logic [VALUE_WIDTH-1:0] value_q [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             count_q;
  logic                   push, pop;
  kwm_ctrl_t              ctrl_in;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    ctrl_in.is_pop  = (func_i == FUNC_POP);
    ctrl_in.bad_run = (func_i == FUNC_LOAD) && ({1'b0, run_index_i} >= (RW+1)'(k_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctrl_q[wr_ptr_q]  <= ctrl_in;
      run_q[wr_ptr_q]   <= run_index_i;
      value_q[wr_ptr_q] <= value_i;
    end
  end

  assign q_ctrl_o  = ctrl_q[rd_ptr_q];
  assign q_run_o   = run_q[rd_ptr_q];
  assign q_value_o = value_q[rd_ptr_q];

endmodule

// ===== design/kwm_back.sv =====
// Back end: run FIFOs, head cache and the sequential winner-tree replay.
module kwm_back import kwm_pkg::*; #(
  parameter int MAX_RUNS    = 16,
  parameter int RUN_DEPTH   = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int RW = $clog2(MAX_RUNS),
  localparam int CW = $clog2(MAX_RUNS + 1),
  localparam int NW = RW + 1,
  localparam int DW = $clog2(RUN_DEPTH),
  localparam int FW = $clog2(RUN_DEPTH + 1),
  localparam int AW = $clog2(MAX_RUNS * RUN_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CW-1:0]          k_i,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  kwm_ctrl_t              q_ctrl_i,
  input  logic [RW-1:0]          q_run_i,
  input  logic [VALUE_WIDTH-1:0] q_value_i,
  input  logic                   res_free_i,
  output logic                   res_valid_o,
  output logic [VALUE_WIDTH-1:0] res_value_o,
  output logic [RW-1:0]          res_run_o,
  output logic [1:0]             res_status_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_TRD  = 8'b0000_0100,
    S_HRD  = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_FIN  = 8'b0010_0000,
    S_NXT  = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] store_mem [MAX_RUNS*RUN_DEPTH];
  logic [VALUE_WIDTH-1:0] hv_mem    [MAX_RUNS];
  logic [RW-1:0]          tree_mem  [MAX_RUNS];
  logic [DW-1:0]          head_q    [MAX_RUNS];
  logic [FW-1:0]          fill_q    [MAX_RUNS];

  logic [RW-1:0]          run_q, node_q, win_q, a_q, b_q, tr0_q, tr1_q, li0_q, li1_q;
  logic                   leaf0_q, leaf1_q, nea_q, neb_q;
  logic [VALUE_WIDTH-1:0] val_q, hva_q, hvb_q, store_rd_q;
  logic [VALUE_WIDTH-1:0] res_value_q;
  logic [RW-1:0]          res_run_q;
  logic [1:0]             res_status_q;

  logic [NW-1:0]          c0, c1, k_n;
  logic [RW-1:0]          a, b, win;
  logic                   left_wins;
  logic [FW:0]            pos_sum;
  logic [DW-1:0]          tail_pos, next_head;

  assign k_n = NW'(k_i);
  assign c0  = {node_q, 1'b0};
  assign c1  = {node_q, 1'b1};
  assign a   = leaf0_q ? li0_q : tr0_q;
  assign b   = leaf1_q ? li1_q : tr1_q;

  assign left_wins = nea_q && (!neb_q || ($signed(hva_q) < $signed(hvb_q)));
  assign win       = left_wins ? a_q : b_q;

  assign pos_sum   = (FW+1)'(head_q[run_q]) + (FW+1)'(fill_q[run_q]);
  assign tail_pos  = (pos_sum >= (FW+1)'(RUN_DEPTH)) ? DW'(pos_sum - (FW+1)'(RUN_DEPTH))
                                                     : DW'(pos_sum);
  assign next_head = (head_q[win_q] == DW'(RUN_DEPTH - 1)) ? '0 : head_q[win_q] + DW'(1);

  assign q_ready_o    = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_RESP) && res_free_i;
  assign res_value_o  = res_value_q;
  assign res_run_o    = res_run_q;
  assign res_status_o = res_status_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_ctrl_i.bad_run)                 state_d = S_RESP;
          else if (!q_ctrl_i.is_pop)            state_d = S_LOAD;
          else if (k_i == CW'(1))               state_d = S_FIN;
          else                                  state_d = S_TRD;
        end
      end
      S_LOAD: state_d = S_RESP;
      S_TRD:  state_d = S_HRD;
      S_HRD:  state_d = S_CMP;
      S_CMP:  state_d = (node_q == RW'(1)) ? S_FIN : S_TRD;
      S_FIN:  state_d = S_NXT;
      S_NXT:  state_d = S_RESP;
      S_RESP: if (res_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < MAX_RUNS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD && fill_q[run_q] != FW'(RUN_DEPTH)) begin
        fill_q[run_q] <= fill_q[run_q] + FW'(1);
      end
      if (state_q == S_NXT && fill_q[win_q] != '0) begin
        fill_q[win_q] <= fill_q[win_q] - FW'(1);
        head_q[win_q] <= next_head;
      end
    end
  end

  // Datapath and memories; no reset needed.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        run_q        <= q_run_i;
        val_q        <= q_value_i;
        node_q       <= RW'(k_i - CW'(1));
        win_q        <= '0;
        res_value_q  <= '0;
        res_run_q    <= '0;
        res_status_q <= ST_BAD_RUN;
      end
      S_LOAD: begin
        if (fill_q[run_q] == FW'(RUN_DEPTH)) begin
          res_status_q <= ST_FULL;
        end else begin
          res_status_q <= ST_OK;
          store_mem[AW'(run_q) * AW'(RUN_DEPTH) + AW'(tail_pos)] <= val_q;
          if (fill_q[run_q] == '0) hv_mem[run_q] <= val_q;
        end
      end
      S_TRD: begin
        // Children below k are internal nodes, the rest are leaves.
        leaf0_q <= (c0 >= k_n);
        leaf1_q <= (c1 >= k_n);
        li0_q   <= RW'(c0 - k_n);
        li1_q   <= RW'(c1 - k_n);
        tr0_q   <= tree_mem[c0[RW-1:0]];
        tr1_q   <= tree_mem[c1[RW-1:0]];
      end
      S_HRD: begin
        a_q   <= a;
        b_q   <= b;
        hva_q <= hv_mem[a];
        hvb_q <= hv_mem[b];
        nea_q <= (fill_q[a] != '0);
        neb_q <= (fill_q[b] != '0);
      end
      S_CMP: begin
        tree_mem[node_q] <= win;
        win_q            <= win;
        node_q           <= node_q - RW'(1);
      end
      S_FIN: begin
        hva_q      <= hv_mem[win_q];
        store_rd_q <= store_mem[AW'(win_q) * AW'(RUN_DEPTH) + AW'(next_head)];
      end
      S_NXT: begin
        if (fill_q[win_q] == '0) begin
          res_status_q <= ST_EMPTY;
        end else begin
          res_status_q <= ST_OK;
          res_value_q  <= hva_q;
          res_run_q    <= win_q;
          if (fill_q[win_q] != FW'(1)) hv_mem[win_q] <= store_rd_q;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

endmodule

// ===== design/kway_merge_winner_tree.sv =====
// Top level of the k-way merge winner tree: config register, front, back, output register.
// Sequence: a load passes a store state before its result, a bad index goes straight
//   to the result, and a pop replays k-1 matches (tree read, head read, compare).
// Throughput: one transaction at a time in the back end; the front queue holds two more,
//   and the output register frees the back end while a result waits.
// Reset: asynchronous active low; clears run heads, fill counts, queue and control state.
module kway_merge_winner_tree import kwm_pkg::*; #(
  parameter int MAX_RUNS    = 16,
  parameter int RUN_DEPTH   = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int RW = $clog2(MAX_RUNS),
  localparam int CW = $clog2(MAX_RUNS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CW-1:0]          cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [RW-1:0]          run_index_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] out_value_o,
  output logic [RW-1:0]          out_run_o,
  output logic [1:0]             status_o
);

  logic [CW-1:0]          num_runs_q, k_eff;
  logic                   q_valid, q_ready;
  kwm_ctrl_t              q_ctrl;
  logic [RW-1:0]          q_run;
  logic [VALUE_WIDTH-1:0] q_value;
  logic                   res_valid, res_free;
  logic [VALUE_WIDTH-1:0] res_value, out_value_q;
  logic [RW-1:0]          res_run, out_run_q;
  logic [1:0]             res_status, status_q;
  logic                   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_runs_q <= CW'(1);
    else if (cfg_we_i) num_runs_q <= cfg_wdata_i;
  end

  // Clamp the run count into 1..MAX_RUNS.
  assign k_eff = (num_runs_q == '0) ? CW'(1) :
                 (num_runs_q > CW'(MAX_RUNS)) ? CW'(MAX_RUNS) : num_runs_q;

  kwm_front #(.MAX_RUNS(MAX_RUNS), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk_i, .rst_ni, .k_i(k_eff),
    .in_valid_i, .in_ready_o, .func_i, .run_index_i, .value_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_ctrl_o(q_ctrl),
    .q_run_o(q_run), .q_value_o(q_value)
  );

  kwm_back #(.MAX_RUNS(MAX_RUNS), .RUN_DEPTH(RUN_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni, .k_i(k_eff),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_ctrl_i(q_ctrl),
    .q_run_i(q_run), .q_value_i(q_value),
    .res_free_i(res_free), .res_valid_o(res_valid), .res_value_o(res_value),
    .res_run_o(res_run), .res_status_o(res_status)
  );

  // Output register: take a new result once the old one is gone or leaving.
  assign res_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (res_free) out_valid_q <= res_valid;
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_value_q <= res_value;
      out_run_q   <= res_run;
      status_q    <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_run_o   = out_run_q;
  assign status_o    = status_q;

endmodule
